// File: hw/rtl/gtc_pkg.sv
// Shared types, constants and tables for the GPS time to calendar converter.
// Depends on nothing; every other file in hw/rtl imports it.
package gtc_pkg;

    localparam int SECS_PER_WEEK     = 604800;
    localparam int WEEK_OFFSET_RESET = 1024;
    localparam int EPOCH_DAY         = 5;
    localparam int BASE_YEAR         = 1980;
    localparam int DAYS_PER_QUAD     = 1461;
    localparam int DAYS_LEAP         = 366;
    localparam int DAYS_COMMON       = 365;
    localparam int SECS_PER_HOUR     = 3600;
    localparam int SECS_PER_MIN      = 60;

    // Reciprocal multipliers; each is exact over the operand range it sees.
    localparam int HOUR_RECIP = 149131;   // tod < 86400, shift 29
    localparam int HOUR_SHIFT = 29;
    localparam int MIN_RECIP  = 4370;     // rem < 3600, shift 18
    localparam int MIN_SHIFT  = 18;
    localparam int QUAD_RECIP = 22967;    // days < 35838, shift 25
    localparam int QUAD_SHIFT = 25;

    // Register stages in each of the date and clock units.
    localparam int SUB_LAT = 5;

    // First second of each weekday within the week.
    localparam logic [19:0] SECS_DAY_START [7] = '{
        20'd0, 20'd86400, 20'd172800, 20'd259200, 20'd345600, 20'd432000, 20'd518400
    };

    // First day of each month, zero based, in a common year.
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [9:0]  gps_week;
        logic [19:0] seconds_of_week;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] year_full;
        logic [4:0]  hour_of_day;
        logic [5:0]  minute_of_hour;
        logic [5:0]  second_of_minute;
        logic        range_error;
    } t_out_word;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_date;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_clock;

    // First day of month index m (0 is January); leap years shift March on.
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        base = MONTH_START[m];
        if (leap && (m >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: hw/rtl/gtc_date.sv
// Date pipeline: week sum and weekday to day, month and full year.
// Five register stages; depends on gtc_pkg.
module gtc_date (
    input  logic                i_clk,
    input  logic [12:0]         i_week_sum,
    input  logic [2:0]          i_dow,
    output gtc_pkg::t_date      o_date
);
    import gtc_pkg::*;

    logic [15:0] r_d1_days;
    logic [15:0] r_d2_days;
    logic [4:0]  r_d2_quads;
    logic [10:0] r_d3_doy;
    logic [4:0]  r_d3_quads;
    logic [8:0]  r_d4_doy;
    logic        r_d4_leap;
    logic [11:0] r_d4_year;
    t_date       r_d5_date;

    logic [15:0] n_d1_days;
    logic [30:0] quad_prod;
    logic [4:0]  n_d2_quads;
    logic [10:0] n_d3_doy;
    logic [10:0] doy_rest;
    logic [1:0]  n_yoff;
    logic [8:0]  n_d4_doy;
    logic        n_d4_leap;
    logic [3:0]  mon_idx;
    logic [8:0]  mon_base;
    t_date       n_d5_date;

    // Stage 1: days since 1 January 1980.
    assign n_d1_days = 16'(i_week_sum) * 16'd7 + 16'(EPOCH_DAY) + 16'(i_dow);

    // Stage 2: four-year cycle count by reciprocal multiply.
    assign quad_prod  = 31'(r_d1_days) * 31'(QUAD_RECIP);
    assign n_d2_quads = 5'(quad_prod >> QUAD_SHIFT);

    // Stage 3: day within the four-year cycle.
    assign n_d3_doy = 11'(r_d2_days - 16'(r_d2_quads) * 16'(DAYS_PER_QUAD));

    // Stage 4: split the cycle into its leap year and three common years.
    always_comb begin
        doy_rest  = r_d3_doy - 11'(DAYS_LEAP);
        n_d4_leap = 1'b0;
        n_yoff    = 2'd0;
        n_d4_doy  = 9'(r_d3_doy);
        if (r_d3_doy < 11'(DAYS_LEAP)) begin
            n_d4_leap = 1'b1;
        end else if (doy_rest < 11'(DAYS_COMMON)) begin
            n_yoff   = 2'd1;
            n_d4_doy = 9'(doy_rest);
        end else if (doy_rest < 11'(2 * DAYS_COMMON)) begin
            n_yoff   = 2'd2;
            n_d4_doy = 9'(doy_rest - 11'(DAYS_COMMON));
        end else begin
            n_yoff   = 2'd3;
            n_d4_doy = 9'(doy_rest - 11'(2 * DAYS_COMMON));
        end
    end

    // Stage 5: find the month by its first day, all compares side by side.
    always_comb begin
        mon_idx  = 4'd0;
        mon_base = 9'd0;
        for (int m = 1; m < 12; m++) begin
            if (r_d4_doy >= month_start(4'(m), r_d4_leap)) begin
                mon_idx  = 4'(m);
                mon_base = month_start(4'(m), r_d4_leap);
            end
        end
        n_d5_date.day   = 5'(r_d4_doy - mon_base + 9'd1);
        n_d5_date.month = mon_idx + 4'd1;
        n_d5_date.year  = r_d4_year;
    end

    always_ff @(posedge i_clk) begin
        r_d1_days  <= n_d1_days;
        r_d2_days  <= r_d1_days;
        r_d2_quads <= n_d2_quads;
        r_d3_doy   <= n_d3_doy;
        r_d3_quads <= r_d2_quads;
        r_d4_doy   <= n_d4_doy;
        r_d4_leap  <= n_d4_leap;
        r_d4_year  <= 12'(BASE_YEAR) + {5'd0, r_d3_quads, 2'b00} + {10'd0, n_yoff};
        r_d5_date  <= n_d5_date;
    end

    assign o_date = r_d5_date;

endmodule

// File: hw/rtl/gtc_clock.sv
// Clock pipeline: second of day to hour, minute and second.
// Five register stages; depends on gtc_pkg.
module gtc_clock (
    input  logic                i_clk,
    input  logic [16:0]         i_tod,
    output gtc_pkg::t_clock     o_clock
);
    import gtc_pkg::*;

    logic [16:0] r_c1_tod;
    logic [4:0]  r_c1_hour;
    logic [11:0] r_c2_rem;
    logic [4:0]  r_c2_hour;
    logic [11:0] r_c3_rem;
    logic [5:0]  r_c3_min;
    logic [4:0]  r_c3_hour;
    t_clock      r_c4_clock;
    t_clock      r_c5_clock;

    logic [34:0] hour_prod;
    logic [24:0] min_prod;
    t_clock      n_c4_clock;

    // Stage 1: hour by reciprocal multiply.
    assign hour_prod = 35'(i_tod) * 35'(HOUR_RECIP);

    // Stage 3: minute by reciprocal multiply of the seconds within the hour.
    assign min_prod = 25'(r_c2_rem) * 25'(MIN_RECIP);

    // Stage 4: second within the minute.
    always_comb begin
        n_c4_clock.hour   = r_c3_hour;
        n_c4_clock.minute = r_c3_min;
        n_c4_clock.second = 6'(r_c3_rem - 12'(r_c3_min) * 12'(SECS_PER_MIN));
    end

    always_ff @(posedge i_clk) begin
        r_c1_tod   <= i_tod;
        r_c1_hour  <= 5'(hour_prod >> HOUR_SHIFT);
        r_c2_rem   <= 12'(r_c1_tod - 17'(r_c1_hour) * 17'(SECS_PER_HOUR));
        r_c2_hour  <= r_c1_hour;
        r_c3_rem   <= r_c2_rem;
        r_c3_min   <= 6'(min_prod >> MIN_SHIFT);
        r_c3_hour  <= r_c2_hour;
        r_c4_clock <= n_c4_clock;
        // Hold one more stage to line up with the date pipeline.
        r_c5_clock <= r_c4_clock;
    end

    assign o_clock = r_c5_clock;

endmodule

// File: hw/rtl/gps_time_to_calendar_unit.sv
// Top level of the GPS week / time-of-week to calendar date converter.
// Depends on gtc_pkg, gtc_date and gtc_clock.
//
//   channel   ports                       handshake
//   --------  --------------------------  ---------------------------------
//   input     start, busy, i_word         word taken when start && !busy
//   result    o_done, o_word              o_done high for one cycle per word
//   config    i_cfg_we, i_cfg_wdata       week_offset written when i_cfg_we
//
// Every word passes from acceptance to o_done through one input stage
// (range check, weekday split, week sum), five stages in the date and clock
// units (set by the reciprocal multiplies and the month search), and one
// output register. A new word may enter every cycle; busy stays low.
// Reset (i_rst_n low, synchronous) clears the valid bits and loads
// week_offset with 1024. The receiver cannot stall, so nothing is held back.
module gps_time_to_calendar_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gtc_pkg::t_in_word    i_word,
    output logic                 o_done,
    output gtc_pkg::t_out_word   o_word,
    input  logic                 i_cfg_we,
    input  logic [11:0]          i_cfg_wdata
);
    import gtc_pkg::*;

    logic [11:0]        r_week_offset;

    // Input stage.
    logic               r_s1_vld;
    logic               r_s1_rng;
    logic [12:0]        r_s1_week_sum;
    logic [2:0]         r_s1_dow;
    logic [16:0]        r_s1_tod;

    // Valid and range flags riding alongside the date and clock units.
    logic [SUB_LAT-1:0] r_vld_sr;
    logic [SUB_LAT-1:0] r_rng_sr;

    logic               r_done;
    t_out_word          r_out_word;

    logic               accept;
    logic [2:0]         n_dow;
    logic [19:0]        n_day_base;
    t_date              date;
    t_clock             clock_fields;
    t_out_word          n_out_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Weekday by comparing against each day's first second; the tod is
    // what remains after the matched day start.
    always_comb begin
        n_dow      = 3'd0;
        n_day_base = SECS_DAY_START[0];
        for (int k = 1; k < 7; k++) begin
            if (i_word.seconds_of_week >= SECS_DAY_START[3'(k)]) begin
                n_dow      = 3'(k);
                n_day_base = SECS_DAY_START[3'(k)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_week_offset <= 12'(WEEK_OFFSET_RESET);
        end else if (i_cfg_we) begin
            r_week_offset <= i_cfg_wdata;
        end
    end

    // Control: valid bits advance every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_vld_sr <= '0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_vld_sr <= {r_vld_sr[SUB_LAT-2:0], r_s1_vld};
            r_done   <= r_vld_sr[SUB_LAT-1];
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_s1_rng      <= i_word.seconds_of_week >= 20'(SECS_PER_WEEK);
        r_s1_week_sum <= 13'(i_word.gps_week) + 13'(r_week_offset);
        r_s1_dow      <= n_dow;
        r_s1_tod      <= 17'(i_word.seconds_of_week - n_day_base);
        r_rng_sr      <= {r_rng_sr[SUB_LAT-2:0], r_s1_rng};
        r_out_word    <= n_out_word;
    end

    gtc_date u_date (
        .i_clk      (i_clk),
        .i_week_sum (r_s1_week_sum),
        .i_dow      (r_s1_dow),
        .o_date     (date)
    );

    gtc_clock u_clock (
        .i_clk   (i_clk),
        .i_tod   (r_s1_tod),
        .o_clock (clock_fields)
    );

    // Drop all date and time fields to zero for an out-of-range time of week.
    always_comb begin
        n_out_word = '0;
        n_out_word.range_error = r_rng_sr[SUB_LAT-1];
        if (!r_rng_sr[SUB_LAT-1]) begin
            n_out_word.day_of_month     = date.day;
            n_out_word.month_number     = date.month;
            n_out_word.year_full        = date.year;
            n_out_word.hour_of_day      = clock_fields.hour;
            n_out_word.minute_of_hour   = clock_fields.minute;
            n_out_word.second_of_minute = clock_fields.second;
        end
    end

    assign o_done = r_done;
    assign o_word = r_out_word;

    // Every accepted word comes out on o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_done)
        else $error("accepted word did not complete after seven cycles");

    // A range error carries an all-zero date and time.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.range_error) |->
            (o_word.day_of_month == 5'd0 && o_word.month_number == 4'd0 &&
             o_word.year_full == 12'd0 && o_word.hour_of_day == 5'd0 &&
             o_word.minute_of_hour == 6'd0 && o_word.second_of_minute == 6'd0))
        else $error("range error word has nonzero fields");

    // A good word carries a sane date.
    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_word.range_error) |->
            (o_word.day_of_month >= 5'd1 && o_word.month_number >= 4'd1 &&
             o_word.month_number <= 4'd12 && o_word.year_full >= 12'd1980 &&
             o_word.year_full <= 12'd2079))
        else $error("date out of range");

    // A good word carries a sane time of day.
    a_time_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_word.range_error) |->
            (o_word.hour_of_day < 5'd24 && o_word.minute_of_hour < 6'd60 &&
             o_word.second_of_minute < 6'd60))
        else $error("time of day out of range");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for gps_time_to_calendar_unit: converts week / seconds words to dates.
// Depends on gtc_pkg for the word types and calendar constants.
module tb_top;

    import gtc_pkg::*;

    localparam int SETTLE_CYCLES = 4;    // quiet cycles before a register write
    localparam int DRAIN_CYCLES  = 16;   // pipeline is 7 deep; wait well past that
    localparam int RANDOM_WORDS  = 650;
    localparam int PHASES        = 6;

    // One entry of the stimulus queue: either a word to convert or a new week offset.
    typedef struct packed {
        logic        is_cfg;
        logic [11:0] cfg_value;
        t_in_word    w;
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_word    i_word = '0;
    logic        o_done;
    t_out_word   o_word;
    logic        i_cfg_we = 1'b0;
    logic [11:0] i_cfg_wdata = '0;

    t_pending    pending[$];
    t_out_word   dates_due[$];

    logic [11:0] offset_now = 12'(WEEK_OFFSET_RESET);
    logic        word_taken = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 1;

    int unsigned n_errors = 0;
    int unsigned n_words = 0;
    int unsigned n_checked = 0;
    int unsigned n_range = 0;
    int unsigned n_cfg = 0;

    gps_time_to_calendar_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .o_done      (o_done),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    function automatic int unsigned month_length(input int unsigned m, input logic leap);
        case (m)
            1:             return leap ? 29 : 28;
            3, 5, 8, 10:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Turn one word into the date and clock it names, under the given week offset.
    function automatic t_out_word calendar_of(input t_in_word w, input logic [11:0] offset);
        t_out_word   r;
        int unsigned secs;
        int unsigned days;
        int unsigned cycles4;
        int unsigned doy;
        int unsigned yr;
        int unsigned tod;
        int unsigned m;
        logic        leap;
        r    = '0;
        secs = 32'(w.seconds_of_week);
        if (secs >= SECS_PER_WEEK) begin
            r.range_error = 1'b1;
            return r;
        end
        // Day 0 is 1 January 1980; the week count starts on 6 January.
        days    = (int'(w.gps_week) + int'(offset)) * 7 + EPOCH_DAY + secs / 86400;
        cycles4 = days / DAYS_PER_QUAD;
        doy     = days % DAYS_PER_QUAD;
        yr      = BASE_YEAR + 4 * cycles4;
        leap    = 1'b1;
        if (doy >= DAYS_LEAP) begin
            doy  = doy - DAYS_LEAP;
            leap = 1'b0;
            yr   = yr + 1 + doy / DAYS_COMMON;
            doy  = doy % DAYS_COMMON;
        end
        // Peel off whole months; December takes whatever is left.
        m = 0;
        while (m < 11 && doy >= month_length(m, leap)) begin
            doy = doy - month_length(m, leap);
            m   = m + 1;
        end
        tod                = secs % 86400;
        r.day_of_month     = 5'(doy + 1);
        r.month_number     = 4'(m + 1);
        r.year_full        = 12'(yr);
        r.hour_of_day      = 5'(tod / SECS_PER_HOUR);
        r.minute_of_hour   = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
        r.second_of_minute = 6'(tod % SECS_PER_MIN);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_word(input int unsigned week, input int unsigned secs);
        t_pending p;
        p                   = '0;
        p.w.gps_week        = 10'(week);
        p.w.seconds_of_week = 20'(secs);
        pending.push_back(p);
    endtask

    // Queue the word that lands on a given day count from 1 January 1980,
    // assuming the reset offset of 1024 weeks.
    task automatic queue_day(input int unsigned day, input int unsigned sod);
        queue_word((day - EPOCH_DAY) / 7 - WEEK_OFFSET_RESET,
                   ((day - EPOCH_DAY) % 7) * 86400 + sod);
    endtask

    task automatic queue_offset(input logic [11:0] value);
        t_pending p;
        p           = '0;
        p.is_cfg    = 1'b1;
        p.cfg_value = value;
        pending.push_back(p);
    endtask

    task automatic flag_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
        n_errors = n_errors + 1;
        $display("[%0t] result %0d: %s got %0d want %0d", $realtime, n_checked, field, got,
                 want);
    endtask

    // ------------------------------------------------------------------
    // Driver: present words in bursts, hold each until taken, and slip
    // offset writes in only once the pipeline has drained.
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin : drive
        logic        nxt_start;
        logic        nxt_we;
        t_in_word    nxt_word;
        logic [11:0] nxt_wdata;
        t_pending    head;
        nxt_start = start;
        nxt_we    = 1'b0;
        nxt_word  = i_word;
        nxt_wdata = i_cfg_wdata;
        if (start && word_taken) begin
            nxt_start = 1'b0;
        end
        if (!i_rst_n || nxt_start || i_cfg_we) begin
            // hold: in reset, word not yet taken, or while a write is being presented
        end else if (gap_left != 0) begin
            gap_left = gap_left - 1;
        end else if (pending.size() != 0) begin
            head = pending[0];
            if (!head.is_cfg) begin
                nxt_start = 1'b1;
                nxt_word  = head.w;
                void'(pending.pop_front());
                burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    // Mostly short bursts with gaps, sometimes a long gapless stretch.
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else if (dates_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                nxt_we    = 1'b1;
                nxt_wdata = head.cfg_value;
                void'(pending.pop_front());
            end
        end
        start       <= nxt_start;
        i_word      <= nxt_word;
        i_cfg_we    <= nxt_we;
        i_cfg_wdata <= nxt_wdata;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted word, track offset writes, and
    // check each o_done word against the oldest prediction.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            word_taken   <= 1'b0;
            quiet_cycles <= 0;
            offset_now    = 12'(WEEK_OFFSET_RESET);
        end else begin
            word_taken <= start && !busy;
            if (start && !busy) begin
                want = calendar_of(i_word, offset_now);
                dates_due.push_back(want);
                n_words = n_words + 1;
                if (want.range_error) begin
                    n_range = n_range + 1;
                end
            end
            if (i_cfg_we) begin
                offset_now = i_cfg_wdata;
                n_cfg      = n_cfg + 1;
            end
            if ($isunknown(o_done)) begin
                flag_mismatch("o_done unknown", 0, 0);
            end else if (o_done) begin
                if (dates_due.size() == 0) begin
                    flag_mismatch("word with nothing pending", 0, 0);
                end else begin
                    want = dates_due.pop_front();
                    if (o_word.day_of_month !== want.day_of_month)
                        flag_mismatch("day_of_month", 32'(o_word.day_of_month),
                                      32'(want.day_of_month));
                    if (o_word.month_number !== want.month_number)
                        flag_mismatch("month_number", 32'(o_word.month_number),
                                      32'(want.month_number));
                    if (o_word.year_full !== want.year_full)
                        flag_mismatch("year_full", 32'(o_word.year_full),
                                      32'(want.year_full));
                    if (o_word.hour_of_day !== want.hour_of_day)
                        flag_mismatch("hour_of_day", 32'(o_word.hour_of_day),
                                      32'(want.hour_of_day));
                    if (o_word.minute_of_hour !== want.minute_of_hour)
                        flag_mismatch("minute_of_hour", 32'(o_word.minute_of_hour),
                                      32'(want.minute_of_hour));
                    if (o_word.second_of_minute !== want.second_of_minute)
                        flag_mismatch("second_of_minute", 32'(o_word.second_of_minute),
                                      32'(want.second_of_minute));
                    if (o_word.range_error !== want.range_error)
                        flag_mismatch("range_error", 32'(o_word.range_error),
                                      32'(want.range_error));
                    n_checked = n_checked + 1;
                end
            end
            quiet_cycles <= (dates_due.size() == 0) ? quiet_cycles + 1 : 0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------

    initial begin : stimulus
        logic [11:0] offsets [PHASES];
        int unsigned r;
        int unsigned wk;
        int unsigned secs;

        // Directed words under the reset offset: field extremes, the range
        // boundary, day edges, and month ends in leap and common years.
        queue_word(0, 0);
        queue_word(1023, SECS_PER_WEEK - 1);
        queue_word(0, SECS_PER_WEEK);
        queue_word(1023, 32'h000FFFFF);
        queue_word(512, 86399);
        queue_word(512, 86400);
        queue_word(341, 32'h00055555);
        queue_word(682, 32'h000AAAAA);
        queue_day(7305, 0);                     // 1 Jan 2000, leap year
        queue_day(7305 + 58, 86399);            // 28 Feb
        queue_day(7305 + 59, 43200);            // leap day
        queue_day(7305 + 60, 0);                // 1 Mar after leap day
        queue_day(7305 + 365, 86399);           // 31 Dec of a leap year
        queue_day(7305 + 366, 0);               // 1 Jan of a common year
        queue_day(7305 + 366 + 58, 3599);       // 28 Feb, common
        queue_day(7305 + 366 + 59, 3600);       // 1 Mar, common
        queue_day(7305 + 366 + 364, 59);        // 31 Dec, common
        queue_day(7305 + 1460, 60);             // last day of a four-year cycle
        queue_day(7305 + 1461, 86340);          // first day of the next cycle
        queue_day(9000, 23 * 3600 + 59 * 60 + 59);

        // Random phases, each under its own week offset, extremes included.
        offsets[0] = 12'd0;
        offsets[1] = 12'hFFF;
        offsets[2] = 12'($urandom_range(1, 4094));
        offsets[3] = 12'(WEEK_OFFSET_RESET);
        offsets[4] = 12'($urandom_range(0, 4095));
        offsets[5] = 12'($urandom_range(0, 4095));
        for (int p = 0; p < PHASES; p++) begin
            queue_offset(offsets[3'(p)]);
            queue_word(0, 0);
            queue_word(1023, SECS_PER_WEEK - 1);
            for (int i = 0; i < RANDOM_WORDS / PHASES; i++) begin
                r  = $urandom_range(0, 99);
                wk = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) * 1023)
                                                  : $urandom_range(0, 1023);
                if (r < 12) begin
                    secs = $urandom_range(SECS_PER_WEEK, 32'h000FFFFF);
                end else if (r < 24) begin
                    secs = $urandom_range(0, 6) * 86400 + $urandom_range(0, 1) * 86399;
                end else begin
                    secs = $urandom_range(0, SECS_PER_WEEK - 1);
                end
                queue_word(wk, secs);
            end
        end

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in and every date to come back.
        while (pending.size() != 0 || start || i_cfg_we || dates_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d words (%0d out of range), checked %0d results",
                 n_words, n_range, n_checked);
        $display("week offset written %0d times, 0 and 4095 among the settings", n_cfg);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Give up if the run hangs; a clean run needs a small fraction of this.
    initial begin : watchdog
        #5ms;
        $display("timeout with %0d words still queued", pending.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
